// ===== rtl/rpti_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpti_pkg: shared types and constants for the rehash probe insert unit
// Item formats, controller states, command and status groups, probe hash.
// ---------------------------------------------------------------------------
package rpti_pkg;

  // Table geometry (power of two, so the hash modulo is a mask)
  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);

  localparam logic [31:0]       HASH_XOR       = 32'd31415927;
  localparam logic [SLOT_W-1:0] HASH_ZERO_SLOT = SLOT_W'(5);
  localparam logic [7:0]        MAX_PROBES_RST = 8'd8;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [31:0] record_key;
    logic [31:0] record_payload;
  } in_item_t;

  typedef struct packed {
    logic        insert_status;
    logic [9:0]  final_slot;
    logic [7:0]  probes_used;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic load;
    logic advance;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic slot_free;
    logic probe_more;
  } status_t;

  // Hash a word to a slot; a zero result is replaced so slot 0 is never used
  function automatic slot_t probe_hash(input logic [31:0] x);
    slot_t h;
    h = x[SLOT_W-1:0] ^ HASH_XOR[SLOT_W-1:0];
    if (h == '0) begin
      h = HASH_ZERO_SLOT;
    end
    return h;
  endfunction

endpackage

// ===== rtl/rehash_probe_table_insert_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rehash_probe_table_insert_unit: open-addressing insert with rehash probing
// Places each record in a 1024-slot table, rehashing the slot until a free
// one is found or the probe limit is reached, and reports the outcome.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_data   (key, payload)
// out       output     out_valid / out_stall out_data  (status, slot, probes)
// cfg       input      cfg_write             cfg_data  (max_probes)
//
// An insert takes the transfer in idle, then a key store read and a check
// per probe, then a finishing step that writes the record if a slot is free.
// After reset a clearing pass zeroes the key store with in_stall high; cfg
// writes are taken throughout.
// A finished result waits in the output register while out_stall is high;
// the next record is taken meanwhile and waits before its write.
// ---------------------------------------------------------------------------
module rehash_probe_table_insert_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpti_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rpti_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data
);
  import rpti_pkg::*;

  cmd_t    cmd;
  status_t status;

  rpti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rpti_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // One record at a time: a transfer in closes the input until done
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an insert is in progress");

  // Slot 0 is never produced by the hash
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.final_slot != 10'd0)
    else $error("result names slot 0");

  // Every result counts at least one probe
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.probes_used != 8'd0)
    else $error("result with zero probes");

  // The insert write and the result load happen only in the finishing step
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !cmd.clear_en && !cmd.load && !cmd.advance)
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/rpti_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpti_ctrl: insert sequencer
// Runs the clearing pass, then takes one record at a time through the
// read / check probe loop and hands the result to the output register.
// ---------------------------------------------------------------------------
module rpti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rpti_pkg::status_t status,
  output rpti_pkg::cmd_t    cmd
);
  import rpti_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.slot_free && status.probe_more) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd = '0;
      end
      ST_CHECK: begin
        cmd.advance = !status.slot_free && status.probe_more;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/rpti_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpti_datapath: key table, probe registers and result register
// Holds the key and payload stores, the probe slot and count, the limit
// register and the output item.
// ---------------------------------------------------------------------------
module rpti_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  rpti_pkg::in_item_t  in_data,
  input  rpti_pkg::cmd_t      cmd,
  output rpti_pkg::status_t   status,
  output rpti_pkg::out_item_t out_data
);
  import rpti_pkg::*;

  logic [31:0] key_store [TABLE_SIZE];
  logic [31:0] payload_store [TABLE_SIZE];

  logic [7:0]  max_probes;
  logic [31:0] key;
  logic [31:0] payload;
  slot_t       slot;
  logic [7:0]  count;
  logic [31:0] rd_key;
  slot_t       clear_idx;

  logic        wr_en;
  slot_t       wr_addr;
  logic [31:0] wr_key;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_probes <= MAX_PROBES_RST;
    end else if (cfg_write) begin
      max_probes <= cfg_data;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (cmd.clear_en) begin
      clear_idx <= clear_idx + 1'b1;
    end
  end

  // Probe registers: load on transfer, rehash the slot on each further probe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= in_data.record_key;
      payload <= in_data.record_payload;
      slot    <= probe_hash(in_data.record_key);
      count   <= 8'd1;
    end else if (cmd.advance) begin
      slot    <= probe_hash({{(32-SLOT_W){1'b0}}, slot});
      count   <= count + 8'd1;
    end
  end

  // Key store write port: clearing pass or a successful insert
  assign wr_en   = cmd.clear_en || (cmd.finish && status.slot_free);
  assign wr_addr = cmd.clear_en ? clear_idx : slot;
  assign wr_key  = cmd.clear_en ? 32'd0 : key;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store[wr_addr] <= wr_key;
    end
    rd_key <= key_store[slot];
  end

  // Payload store, written alongside the key on insert
  always_ff @(posedge clk) begin
    if (cmd.finish && status.slot_free) begin
      payload_store[slot] <= payload;
    end
  end

  assign status.clear_last = (clear_idx == slot_t'(TABLE_SIZE - 1));
  assign status.slot_free  = (rd_key == 32'd0);
  assign status.probe_more = (count < max_probes);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.insert_status <= !status.slot_free;
      out_data.final_slot    <= 10'(slot);
      out_data.probes_used   <= count;
    end
  end

endmodule
